// ===== rtl/core/ppd_pkg.sv =====
// Shared types and constants of the peak-preserving decimator.
// Used by the channel interfaces, the register block, the bucket datapath
// and the top level. No dependencies.
package ppd_pkg;

  // Field and counter widths
  localparam int SAMPLE_WIDTH     = 16;
  localparam int MAX_FRAME        = 65536;
  localparam int MAX_POINTS_LIMIT = 4096;
  localparam int FRAME_W          = 17;
  localparam int POINTS_W         = 13;
  localparam int CNT_W            = 16;
  localparam int ACC_W            = 19;
  localparam int PADDR_W          = 3;
  localparam int PDATA_W          = 32;

  // Register reset values
  localparam logic [FRAME_W-1:0]  FRAME_LENGTH_RESET = FRAME_W'(4096);
  localparam logic [POINTS_W-1:0] MAX_POINTS_RESET   = POINTS_W'(2048);

  // Register indexes, taken from paddr[2]
  typedef enum logic {
    REG_FRAME_LENGTH = 1'b0,
    REG_MAX_POINTS   = 1'b1
  } reg_idx_t;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // Effective configuration seen by the datapath
  typedef struct packed {
    logic [FRAME_W-1:0]  n;
    logic [POINTS_W-1:0] m;
    logic                pass;
  } cfg_t;

  // One preview point plus its presence flag
  typedef struct packed {
    logic                 has;
    sample_t              value;
    logic                 finite;
    logic [CNT_W-1:0]     number;
    logic                 last;
  } point_t;

endpackage

// ===== rtl/core/ppd_smp_if.sv =====
// Sample channel of the peak-preserving decimator: valid/ready plus payload.
// Depends on ppd_pkg for the sample type.
interface ppd_smp_if;
  logic             valid;
  logic             ready;
  ppd_pkg::sample_t sample_value;
  logic             sample_finite;

  modport source (output valid, sample_value, sample_finite, input ready);
  modport sink   (input valid, sample_value, sample_finite, output ready);
endinterface

// ===== rtl/core/ppd_pt_if.sv =====
// Preview point channel of the peak-preserving decimator.
// Depends on ppd_pkg for the sample type and widths.
interface ppd_pt_if;
  logic                        valid;
  logic                        ready;
  ppd_pkg::sample_t            point_value;
  logic                        point_finite;
  logic [ppd_pkg::CNT_W-1:0]   point_number;
  logic                        frame_last;

  modport source (output valid, point_value, point_finite, point_number, frame_last,
                  input ready);
  modport sink   (input valid, point_value, point_finite, point_number, frame_last,
                  output ready);
endinterface

// ===== rtl/core/peak_preserving_decimator.sv =====
// Peak-preserving decimator, top level. Uses ppd_pkg, ppd_smp_if, ppd_pt_if,
// ppd_cfg and ppd_bucket.
//
// Samples enter on in_smp (valid/ready); one transfer per sample. Preview
// points leave on out_pt, each with its index in the frame and a last-point
// flag. A frame of frame_length samples gives every sample back when it is
// no longer than max_points; otherwise it gives one point per bucket, the
// bucket extreme of larger magnitude (zero for a bucket with no finite sample).
// Registers are written over the APB-style port (0x0 frame_length,
// 0x4 max_points); any write restarts the frame, so write only while idle.
// A sample passes through an input register, then through the bucket logic
// into the output register. Throughput is one sample per cycle unless a
// held point on out_pt blocks a sample that produces a point.
// When out_pt stalls, a held point blocks only samples that produce a point;
// samples inside a bucket keep flowing. Synchronous active-low reset clears
// both valid flags, the counters and the bucket, and restores register defaults.
module peak_preserving_decimator (
  input  logic                         clk,
  input  logic                         rst_n,
  ppd_smp_if.sink                      in_smp,
  ppd_pt_if.source                     out_pt,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppd_pkg::PADDR_W-1:0]  paddr,
  input  logic [ppd_pkg::PDATA_W-1:0]  pwdata,
  output logic [ppd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import ppd_pkg::*;

  cfg_t    cfg;
  logic    restart;
  point_t  point;

  logic    s1_valid_r, s1_valid_nxt;
  sample_t s1_value_r;
  logic    s1_finite_r;
  logic    s1_adv;
  logic    in_xfer;
  logic    load;

  logic    out_valid_r, out_valid_nxt;
  point_t  out_r;

  ppd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .restart (restart)
  );

  ppd_bucket u_bucket (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .restart       (restart),
    .step          (s1_adv),
    .sample_value  (s1_value_r),
    .sample_finite (s1_finite_r),
    .point         (point)
  );

  // Advance the input stage unless its point has nowhere to go
  assign s1_adv       = s1_valid_r & (~point.has | ~out_valid_r | out_pt.ready);
  assign in_smp.ready = ~s1_valid_r | s1_adv;
  assign in_xfer      = in_smp.valid & in_smp.ready;
  assign load         = s1_adv & point.has;

  always_comb begin
    s1_valid_nxt = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    if (load)
      out_valid_nxt = 1'b1;
    else if (out_pt.ready)
      out_valid_nxt = 1'b0;
    else
      out_valid_nxt = out_valid_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_value_r  <= in_smp.sample_value;
      s1_finite_r <= in_smp.sample_finite;
    end
    if (load) begin
      out_r <= point;
    end
  end

  assign out_pt.valid        = out_valid_r;
  assign out_pt.point_value  = out_r.value;
  assign out_pt.point_finite = out_r.finite;
  assign out_pt.point_number = out_r.number;
  assign out_pt.frame_last   = out_r.last;
endmodule

// ===== rtl/core/ppd_cfg.sv =====
// APB-style register block: frame_length and max_points, clamped views.
// Pulses a frame restart on every register write. Depends on ppd_pkg.
module ppd_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppd_pkg::PADDR_W-1:0]  paddr,
  input  logic [ppd_pkg::PDATA_W-1:0]  pwdata,
  output logic [ppd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output ppd_pkg::cfg_t                cfg,
  output logic                         restart
);
  import ppd_pkg::*;

  logic [FRAME_W-1:0]  frame_length_r;
  logic [POINTS_W-1:0] max_points_r;
  logic                wr_en;
  reg_idx_t            idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign idx     = reg_idx_t'(paddr[2]);
  assign restart = wr_en;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= FRAME_LENGTH_RESET;
      max_points_r   <= MAX_POINTS_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_FRAME_LENGTH: frame_length_r <= pwdata[FRAME_W-1:0];
        REG_MAX_POINTS:   max_points_r   <= pwdata[POINTS_W-1:0];
        default: ;
      endcase
    end
  end

  // Readback
  always_comb begin
    case (idx)
      REG_FRAME_LENGTH: prdata = PDATA_W'(frame_length_r);
      REG_MAX_POINTS:   prdata = PDATA_W'(max_points_r);
      default:          prdata = '0;
    endcase
  end

  // Clamp: zero acts as one, oversize acts as the limit
  always_comb begin
    if (frame_length_r == '0)
      cfg.n = FRAME_W'(1);
    else if (frame_length_r > FRAME_W'(MAX_FRAME))
      cfg.n = FRAME_W'(MAX_FRAME);
    else
      cfg.n = frame_length_r;

    if (max_points_r == '0)
      cfg.m = POINTS_W'(1);
    else if (max_points_r > POINTS_W'(MAX_POINTS_LIMIT))
      cfg.m = POINTS_W'(MAX_POINTS_LIMIT);
    else
      cfg.m = max_points_r;

    cfg.pass = (cfg.n <= FRAME_W'(cfg.m));
  end
endmodule

// ===== rtl/core/ppd_bucket.sv =====
// Bucket datapath: sample counter, boundary accumulator, running min/max
// and the point it yields for the registered sample. Depends on ppd_pkg.
module ppd_bucket (
  input  logic              clk,
  input  logic              rst_n,
  input  ppd_pkg::cfg_t     cfg,
  input  logic              restart,
  input  logic              step,
  input  ppd_pkg::sample_t  sample_value,
  input  logic              sample_finite,
  output ppd_pkg::point_t   point
);
  import ppd_pkg::*;

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]        pnum_r, pnum_nxt;
  sample_t                 min_r, min_nxt;
  sample_t                 max_r, max_nxt;
  logic                    has_r, has_nxt;

  logic [FRAME_W-1:0]      j1;
  logic                    last;
  sample_t                 min_upd, max_upd;
  logic                    has_upd;
  logic signed [ACC_W-1:0] m_s, n_s, t, t2;
  logic                    emit;
  logic [SAMPLE_WIDTH:0]   amax, amin, mx_ext, mn_ext;
  sample_t                 pick;

  localparam sample_t MOST_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  always_comb begin
    // Frame position
    j1   = FRAME_W'(cnt_r) + FRAME_W'(1);
    last = (j1 >= cfg.n);

    // Fold the sample into the bucket extremes
    min_upd = min_r;
    max_upd = max_r;
    if (sample_finite) begin
      if (sample_value < min_r) min_upd = sample_value;
      if (sample_value > max_r) max_upd = sample_value;
    end
    has_upd = has_r | sample_finite;

    // Bucket boundary test
    m_s  = $signed(ACC_W'(cfg.m));
    n_s  = $signed(ACC_W'(cfg.n));
    t    = acc_r + m_s;
    t2   = t + m_s;
    emit = last || (t2 > n_s);

    // Extreme of larger magnitude, max on a tie
    mx_ext = {max_upd[SAMPLE_WIDTH-1], max_upd};
    mn_ext = {min_upd[SAMPLE_WIDTH-1], min_upd};
    amax   = mx_ext[SAMPLE_WIDTH] ? (~mx_ext + 1'b1) : mx_ext;
    amin   = mn_ext[SAMPLE_WIDTH] ? (~mn_ext + 1'b1) : mn_ext;
    if (!has_upd)
      pick = '0;
    else if (amax >= amin)
      pick = max_upd;
    else
      pick = min_upd;

    // Result
    if (cfg.pass) begin
      point.has    = 1'b1;
      point.value  = sample_value;
      point.finite = sample_finite;
      point.number = cnt_r;
    end else begin
      point.has    = emit;
      point.value  = pick;
      point.finite = 1'b1;
      point.number = pnum_r;
    end
    point.last = last;

    // Next state
    cnt_nxt  = last ? '0 : j1[CNT_W-1:0];
    acc_nxt  = acc_r;
    pnum_nxt = pnum_r;
    min_nxt  = min_r;
    max_nxt  = max_r;
    has_nxt  = has_r;
    if (!cfg.pass) begin
      if (emit) begin
        acc_nxt  = t - n_s;
        pnum_nxt = pnum_r + CNT_W'(1);
        min_nxt  = MOST_POS;
        max_nxt  = MOST_NEG;
        has_nxt  = 1'b0;
      end else begin
        acc_nxt  = t;
        min_nxt  = min_upd;
        max_nxt  = max_upd;
        has_nxt  = has_upd;
      end
    end
    // Restart counters at the end of a frame
    if (last) begin
      acc_nxt  = '0;
      pnum_nxt = '0;
      min_nxt  = MOST_POS;
      max_nxt  = MOST_NEG;
      has_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      cnt_r  <= '0;
      acc_r  <= '0;
      pnum_r <= '0;
      min_r  <= MOST_POS;
      max_r  <= MOST_NEG;
      has_r  <= 1'b0;
    end else if (step) begin
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      pnum_r <= pnum_nxt;
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      has_r  <= has_nxt;
    end
  end
endmodule
